>>> src/mpph_pkg.sv
// Shared types, codes and constants of the multipart part header parser.
`default_nettype none

package mpph_pkg;

    // Default boundary capacity in bytes
    localparam int MAX_BOUNDARY_DEF = 70;

    // Command queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = $clog2(QUEUE_DEPTH);

    // Input modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_BOUND  = 2'd1;
    localparam logic [1:0] MODE_BODY   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Queued operations
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_BODY   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_PART      = 3'd0;
    localparam logic [2:0] ST_CLOSE     = 3'd1;
    localparam logic [2:0] ST_DASHES    = 3'd2;
    localparam logic [2:0] ST_MISMATCH  = 3'd3;
    localparam logic [2:0] ST_MALFORMED = 3'd4;

    // Characters
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    // "--" plus the two tail bytes
    localparam logic [31:0] MIN_EXTRA = 32'd4;

    // Smallest offset of a found part: "--", CRLF, empty line CRLF
    localparam logic [31:0] MIN_PART_OFFSET = 32'd6;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] part_offset;
    } out_item_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       last;
        logic       is_dash;
        logic       is_cr;
        logic       is_lf;
    } cmd_t;

endpackage

`default_nettype wire

>>> src/multipart_part_header_parser_core.sv
// Top level of the multipart part header parser: front, command queue, back.
`default_nettype none

// Takes one item per clock and sustains one item per cycle while nothing
// stalls. An item is classified in the front part, is registered in a
// four-entry command queue, and is executed by the back part, which compares
// the boundary bytes of the body against boundary bytes prefetched from the
// boundary RAM the cycle before; the result of the last body byte is held in
// the output register. A stalled result holds the back part, and the input
// stalls once the queue fills. The boundary RAM needs no clearing after
// reset, so the block accepts items from the first cycle. Only a body item
// flagged as the last byte produces a result.

module multipart_part_header_parser_core
    import mpph_pkg::*;
#(
    parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output logic           item_stall,
    input  wire in_item_t  item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result
);

    logic f_valid, f_stall;
    cmd_t f_cmd;
    logic q_valid, q_stall;
    cmd_t q_cmd;

    mpph_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_valid  (f_valid),
        .cmd_stall  (f_stall),
        .cmd        (f_cmd)
    );

    mpph_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_stall (f_stall),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_stall  (q_stall),
        .pop_data   (q_cmd)
    );

    mpph_back #(
        .MAX_BOUNDARY (MAX_BOUNDARY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd_stall    (q_stall),
        .cmd          (q_cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_PART |-> result.part_offset == '0)
        else $error("nonzero offset on a status other than part found");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status <= ST_MALFORMED)
        else $error("status code out of range");

    a_part_offset_min: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_PART |-> result.part_offset >= MIN_PART_OFFSET)
        else $error("part offset shorter than dashes and two line ends");

    a_no_result_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid && !result_valid |=> !result_valid)
        else $error("result without a queued command");

endmodule

`default_nettype wire

>>> src/mpph_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mpph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 70
) (
    input  wire logic                                          clk,
    input  wire logic                                          we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                              wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/mpph_front.sv
// Front part: accepts input items and turns them into queued commands.
`default_nettype none

module mpph_front
    import mpph_pkg::*;
(
    input  wire logic     item_valid,
    output logic          item_stall,
    input  wire in_item_t item,
    output logic          cmd_valid,
    input  wire logic     cmd_stall,
    output cmd_t          cmd
);

    // Unknown mode is accepted and dropped
    assign cmd_valid  = item_valid && (item.mode != MODE_UNUSED);
    assign item_stall = cmd_stall;

    always_comb
    begin
        cmd.data    = item.data_byte;
        cmd.last    = item.last_byte;
        cmd.is_dash = (item.data_byte == CH_DASH);
        cmd.is_cr   = (item.data_byte == CH_CR);
        cmd.is_lf   = (item.data_byte == CH_LF);
        case (item.mode)
            MODE_START: cmd.op = OP_CLEAR;
            MODE_BOUND: cmd.op = OP_APPEND;
            MODE_BODY:  cmd.op = OP_BODY;
            default:    cmd.op = OP_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

>>> src/mpph_queue.sv
// Short command queue decoupling the front and back parts.
`default_nettype none

module mpph_queue
    import mpph_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_stall,
    input  wire cmd_t push_data,
    output logic      pop_valid,
    input  wire logic pop_stall,
    output cmd_t      pop_data
);

    cmd_t           mem_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           push, pop;

    assign push_stall = (count_reg == (QAW+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    assign push = push_valid && !push_stall;
    assign pop  = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> src/mpph_back.sv
// Back part: boundary store, body parser and result register.
`default_nettype none

module mpph_back
    import mpph_pkg::*;
#(
    parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      result_valid,
    input  wire logic result_stall,
    output out_item_t result
);

    localparam int BW = $clog2(MAX_BOUNDARY + 1);
    localparam int AW = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
    localparam logic [BW-1:0] MAX_CNT = BW'(MAX_BOUNDARY);

    localparam logic [2:0] PH_DASH1     = 3'd0;
    localparam logic [2:0] PH_DASH2     = 3'd1;
    localparam logic [2:0] PH_BOUND     = 3'd2;
    localparam logic [2:0] PH_TAIL1     = 3'd3;
    localparam logic [2:0] PH_TAIL_DASH = 3'd4;
    localparam logic [2:0] PH_TAIL_CR   = 3'd5;
    localparam logic [2:0] PH_HEAD      = 3'd6;
    localparam logic [2:0] PH_DONE      = 3'd7;

    localparam logic [1:0] LT_START    = 2'd0;
    localparam logic [1:0] LT_START_CR = 2'd1;
    localparam logic [1:0] LT_TEXT     = 2'd2;
    localparam logic [1:0] LT_TEXT_CR  = 2'd3;

    logic [BW-1:0]  count_reg, count_next;
    logic [2:0]     phase_reg, phase_next;
    logic [BW-1:0]  mi_reg, mi_next;
    logic [31:0]    body_reg, body_next;
    logic [1:0]     lt_reg, lt_next;
    logic [2:0]     hstat_reg, hstat_next;
    logic [31:0]    hoff_reg, hoff_next;
    logic           res_valid_reg, res_valid_next;
    out_item_t      res_reg, res_next;
    logic           hit_reg;
    logic [7:0]     byp_reg;

    logic           take;
    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [7:0]     ram_rdata, cur_byte;
    logic [2:0]     phase_eff;
    logic [BW:0]    mi_inc;

    mpph_ram #(
        .WIDTH (8),
        .DEPTH (MAX_BOUNDARY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (cmd.data),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign cmd_stall = res_valid_reg && result_stall;
    assign take      = cmd_valid && !cmd_stall;
    assign waddr     = count_reg[AW-1:0];
    assign we        = take && (cmd.op == OP_APPEND) && (count_reg < MAX_CNT);
    // Prefetch the boundary byte for the next compare
    assign raddr     = (mi_next < MAX_CNT) ? mi_next[AW-1:0] : '0;
    assign cur_byte  = hit_reg ? byp_reg : ram_rdata;
    assign mi_inc    = {1'b0, mi_reg} + 1'b1;
    assign phase_eff = (phase_reg == PH_BOUND && mi_reg >= count_reg) ? PH_TAIL1 : phase_reg;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        count_next     = count_reg;
        phase_next     = phase_reg;
        mi_next        = mi_reg;
        body_next      = body_reg;
        lt_next        = lt_reg;
        hstat_next     = hstat_reg;
        hoff_next      = hoff_reg;
        res_valid_next = res_valid_reg && result_stall;
        res_next       = res_reg;

        if (take)
        begin
            case (cmd.op)
                OP_CLEAR:
                begin
                    count_next = '0;
                    phase_next = PH_DASH1;
                    mi_next    = '0;
                    body_next  = '0;
                    lt_next    = LT_START;
                    hstat_next = ST_MALFORMED;
                    hoff_next  = '0;
                end
                OP_APPEND:
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_BODY:
                begin
                    body_next = (body_reg == '1) ? body_reg : body_reg + 32'd1;
                    case (phase_eff)
                        PH_DASH1:
                        begin
                            if (cmd.is_dash)
                            begin
                                phase_next = PH_DASH2;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                                hstat_next = ST_DASHES;
                                hoff_next  = '0;
                            end
                        end
                        PH_DASH2:
                        begin
                            if (cmd.is_dash)
                            begin
                                mi_next    = '0;
                                phase_next = (count_reg == '0) ? PH_TAIL1 : PH_BOUND;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                                hstat_next = ST_DASHES;
                                hoff_next  = '0;
                            end
                        end
                        PH_BOUND:
                        begin
                            if (cur_byte != cmd.data)
                            begin
                                phase_next = PH_DONE;
                                hstat_next = ST_MISMATCH;
                                hoff_next  = '0;
                            end
                            else
                            begin
                                mi_next = mi_inc[BW-1:0];
                                if (mi_inc >= {1'b0, count_reg})
                                begin
                                    phase_next = PH_TAIL1;
                                end
                            end
                        end
                        PH_TAIL1:
                        begin
                            if (cmd.is_dash)
                            begin
                                phase_next = PH_TAIL_DASH;
                            end
                            else if (cmd.is_cr)
                            begin
                                phase_next = PH_TAIL_CR;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                                hstat_next = ST_MALFORMED;
                                hoff_next  = '0;
                            end
                        end
                        PH_TAIL_DASH:
                        begin
                            phase_next = PH_DONE;
                            hstat_next = cmd.is_dash ? ST_CLOSE : ST_MALFORMED;
                            hoff_next  = '0;
                        end
                        PH_TAIL_CR:
                        begin
                            if (cmd.is_lf)
                            begin
                                phase_next = PH_HEAD;
                                lt_next    = LT_START;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                                hstat_next = ST_MALFORMED;
                                hoff_next  = '0;
                            end
                        end
                        PH_HEAD:
                        begin
                            case (lt_reg)
                                LT_START:
                                begin
                                    lt_next = cmd.is_cr ? LT_START_CR : LT_TEXT;
                                end
                                LT_START_CR:
                                begin
                                    // empty line ends the headers
                                    if (cmd.is_lf)
                                    begin
                                        phase_next = PH_DONE;
                                        hstat_next = ST_PART;
                                        hoff_next  = body_next;
                                    end
                                    else
                                    begin
                                        lt_next = cmd.is_cr ? LT_TEXT_CR : LT_TEXT;
                                    end
                                end
                                LT_TEXT:
                                begin
                                    lt_next = cmd.is_cr ? LT_TEXT_CR : LT_TEXT;
                                end
                                default:
                                begin
                                    if (cmd.is_lf)
                                    begin
                                        lt_next = LT_START;
                                    end
                                    else
                                    begin
                                        lt_next = cmd.is_cr ? LT_TEXT_CR : LT_TEXT;
                                    end
                                end
                            endcase
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase

                    if (cmd.last)
                    begin
                        res_valid_next = 1'b1;
                        if (body_next < (32'(count_reg) + MIN_EXTRA) || phase_next != PH_DONE)
                        begin
                            res_next.status      = ST_MALFORMED;
                            res_next.part_offset = '0;
                        end
                        else
                        begin
                            res_next.status      = hstat_next;
                            res_next.part_offset = (hstat_next == ST_PART) ? hoff_next : '0;
                        end
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            phase_reg     <= PH_DASH1;
            mi_reg        <= '0;
            body_reg      <= '0;
            lt_reg        <= LT_START;
            hstat_reg     <= ST_MALFORMED;
            hoff_reg      <= '0;
            res_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            mi_reg        <= mi_next;
            body_reg      <= body_next;
            lt_reg        <= lt_next;
            hstat_reg     <= hstat_next;
            hoff_reg      <= hoff_next;
            res_valid_reg <= res_valid_next;
            // write and prefetch at the same address: forward the new byte
            hit_reg       <= we && (waddr == raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        byp_reg <= cmd.data;
    end

endmodule

`default_nettype wire
